// ===== rtl/pptr_pkg.sv =====
// ----------------------------------------------------------------------------
// pptr_pkg
// Shared constants, types and helpers of the panorama pixel-to-ray block.
// ----------------------------------------------------------------------------
package pptr_pkg;

  localparam int PIXEL_FRAC_BITS_DEF = 4;
  localparam int DIR_FRAC_BITS_DEF   = 14;
  localparam int CORDIC_STAGES_DEF   = 16;

  localparam int MAX_STAGES = 24;
  localparam int REG_W      = 13;
  localparam int ANG_W      = 16;
  localparam int OUT_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int NUM_W      = 36;
  localparam int XW         = 33;
  localparam int ZW         = 34;
  localparam int PROD_W     = 2 * XW;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AZIMUTH_OFFSET = 2'd2;

  localparam logic [REG_W-1:0] WIDTH_RST  = 13'd720;
  localparam logic [REG_W-1:0] HEIGHT_RST = 13'd576;

  localparam logic signed [XW-1:0] INV_GAIN_Q30 = 33'sd652032874;
  localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [ZW-1:0] HALF_TURN    = 34'sd2147483648;

  localparam logic [31:0] ATAN_TURN [MAX_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } rot_t;

  function automatic logic [OUT_W-1:0] round_sat16(input logic signed [PROD_W-1:0] v,
                                                   input int s);
    logic              neg;
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] rnd;
    logic [OUT_W-1:0]  res;
    neg = v[PROD_W-1];
    mag = neg ? PROD_W'(-v) : PROD_W'(v);
    rnd = (mag + (PROD_W'(1) << (s - 1))) >> s;
    if (rnd > PROD_W'(32768)) begin
      rnd = PROD_W'(32768);
    end
    if (neg) begin
      res = OUT_W'(-rnd[OUT_W-1:0]);
    end else if (rnd > PROD_W'(32767)) begin
      res = 16'h7FFF;
    end else begin
      res = rnd[OUT_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/pptr_div_cell.sv =====
// ----------------------------------------------------------------------------
// pptr_div_cell
// One restoring-division cell: resolves one quotient bit per clock.
// ----------------------------------------------------------------------------
module pptr_div_cell #(
  parameter int DEN_W = 19
) (
  input  logic                     clk,
  input  logic [pptr_pkg::NUM_W-1:0] num_i,
  input  logic [pptr_pkg::NUM_W-1:0] quo_i,
  input  logic [DEN_W-1:0]         rem_i,
  input  logic [DEN_W-1:0]         den_i,
  output logic [pptr_pkg::NUM_W-1:0] num_o,
  output logic [pptr_pkg::NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0]         rem_o
);
  import pptr_pkg::*;

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   diff;
  logic [NUM_W-1:0] num_r, quo_r;
  logic [DEN_W-1:0] rem_r;

  assign trial = {rem_i, num_i[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_i};
  assign diff  = trial - {1'b0, den_i};

  always_ff @(posedge clk) begin
    num_r <= {num_i[NUM_W-2:0], 1'b0};
    quo_r <= {quo_i[NUM_W-2:0], ge};
    rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  assign num_o = num_r;
  assign quo_o = quo_r;
  assign rem_o = rem_r;
endmodule

// ===== rtl/pptr_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// pptr_cordic_cell
// One rotation-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module pptr_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  pptr_pkg::rot_t  rot_i,
  output pptr_pkg::rot_t  rot_o
);
  import pptr_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = ZW'(ATAN_TURN[STAGE]);

  rot_t rot_nxt, rot_r;
  logic signed [XW-1:0] xs, ys;

  assign xs = rot_i.x >>> STAGE;
  assign ys = rot_i.y >>> STAGE;

  always_comb begin
    rot_nxt      = rot_i;
    if (!rot_i.z[ZW-1]) begin
      rot_nxt.x = rot_i.x - ys;
      rot_nxt.y = rot_i.y + xs;
      rot_nxt.z = rot_i.z - ATAN;
    end else begin
      rot_nxt.x = rot_i.x + ys;
      rot_nxt.y = rot_i.y - xs;
      rot_nxt.z = rot_i.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    rot_r <= rot_nxt;
  end

  assign rot_o = rot_r;
endmodule

// ===== rtl/panorama_pixel_to_ray_direction_top.sv =====
// ----------------------------------------------------------------------------
// panorama_pixel_to_ray_direction_top
// Equirectangular pixel-to-ray: divider cell chains, CORDIC cell chains,
// direction products.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+-------------------
//   input    | in_column_pos, in_row_pos               | start & !busy
//   result   | out_azimuth/polar, out_dir_x/y/z        | out_valid strobe
//   config   | cfg_we, cfg_idx, cfg_data               | cfg_we
//
// One beat per clock in, one per clock out; busy stays low.
// Path: input regs, the 36-cell divider chain, angle and fold regs, the
// CORDIC chain, undo-fold, product and output regs. Synchronous reset
// clears the valid line and config registers. The receiver cannot stall.
// ----------------------------------------------------------------------------
module panorama_pixel_to_ray_direction_top #(
  parameter int PIXEL_FRAC_BITS = pptr_pkg::PIXEL_FRAC_BITS_DEF,
  parameter int DIR_FRAC_BITS   = pptr_pkg::DIR_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = pptr_pkg::CORDIC_STAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [15:0]                    in_column_pos,
  input  logic [15:0]                    in_row_pos,
  output logic                           out_valid,
  output logic [15:0]                    out_azimuth,
  output logic [15:0]                    out_polar,
  output logic signed [15:0]             out_dir_x,
  output logic signed [15:0]             out_dir_y,
  output logic signed [15:0]             out_dir_z,
  input  logic                           cfg_we,
  input  logic [pptr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [pptr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pptr_pkg::*;

  localparam int P     = PIXEL_FRAC_BITS;
  localparam int DEN_W = REG_W + P + 2;
  localparam int CS    = CORDIC_STAGES;
  localparam int DLY   = CS + 3;
  localparam int LAT   = NUM_W + CS + 6;

  logic [REG_W-1:0] width_r, height_r, width_nxt, height_nxt;
  logic [ANG_W-1:0] offset_r, offset_nxt;
  logic [LAT-1:0]   vld_r, vld_nxt;
  logic             acc;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    offset_nxt = offset_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IMAGE_WIDTH:    width_nxt  = cfg_data[REG_W-1:0];
        CFG_IMAGE_HEIGHT:   height_nxt = cfg_data[REG_W-1:0];
        CFG_AZIMUTH_OFFSET: offset_nxt = cfg_data;
        default: ;
      endcase
    end
    vld_nxt = {vld_r[LAT-2:0], acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      offset_r <= '0;
      vld_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      offset_r <= offset_nxt;
      vld_r    <= vld_nxt;
    end
  end

  // divisor setup
  logic [REG_W-1:0] wz, hz;
  logic [DEN_W-1:0] den_col, den_row;
  assign wz      = (width_r == '0) ? REG_W'(1) : width_r;
  assign hz      = (height_r == '0) ? REG_W'(1) : height_r;
  assign den_col = DEN_W'(wz) << (P + 2);
  assign den_row = DEN_W'(hz) << (P + 2);

  logic [17:0]      cn, rn;
  logic [NUM_W-1:0] num_col_r, num_row_r;
  assign cn = {1'b0, in_column_pos, 1'b0} + 18'(1 << P);
  assign rn = {1'b0, in_row_pos, 1'b0} + 18'(1 << P);

  always_ff @(posedge clk) begin
    num_col_r <= (NUM_W'(cn) << 17) + (NUM_W'(wz) << (P + 1));
    num_row_r <= (NUM_W'(rn) << 16) + (NUM_W'(hz) << (P + 1));
  end

  logic [NUM_W-1:0] cnum_w [NUM_W+1];
  logic [NUM_W-1:0] cquo_w [NUM_W+1];
  logic [DEN_W-1:0] crem_w [NUM_W+1];
  logic [NUM_W-1:0] rnum_w [NUM_W+1];
  logic [NUM_W-1:0] rquo_w [NUM_W+1];
  logic [DEN_W-1:0] rrem_w [NUM_W+1];

  assign cnum_w[0] = num_col_r;
  assign cquo_w[0] = '0;
  assign crem_w[0] = '0;
  assign rnum_w[0] = num_row_r;
  assign rquo_w[0] = '0;
  assign rrem_w[0] = '0;

  for (genvar i = 0; i < NUM_W; i++) begin : g_div
    pptr_div_cell #(.DEN_W(DEN_W)) u_col (
      .clk(clk), .num_i(cnum_w[i]), .quo_i(cquo_w[i]), .rem_i(crem_w[i]),
      .den_i(den_col), .num_o(cnum_w[i+1]), .quo_o(cquo_w[i+1]), .rem_o(crem_w[i+1])
    );
    pptr_div_cell #(.DEN_W(DEN_W)) u_row (
      .clk(clk), .num_i(rnum_w[i]), .quo_i(rquo_w[i]), .rem_i(rrem_w[i]),
      .den_i(den_row), .num_o(rnum_w[i+1]), .quo_o(rquo_w[i+1]), .rem_o(rrem_w[i+1])
    );
  end

  // angles
  logic [ANG_W-1:0] az_r, pol_r;
  always_ff @(posedge clk) begin
    az_r  <= 16'h8000 - cquo_w[NUM_W][ANG_W-1:0] + offset_r;
    pol_r <= (rquo_w[NUM_W] > NUM_W'(32768)) ? 16'h8000 : rquo_w[NUM_W][ANG_W-1:0];
  end

  // fold to within a quarter turn
  function automatic rot_t fold(input logic [ANG_W-1:0] a);
    rot_t r;
    logic signed [ZW-1:0] z;
    z      = ZW'(signed'({a, 16'h0000}));
    r.x    = INV_GAIN_Q30;
    r.y    = '0;
    r.flip = 1'b0;
    if (z > QUARTER_TURN) begin
      z      = z - HALF_TURN;
      r.flip = 1'b1;
    end else if (z < -QUARTER_TURN) begin
      z      = z + HALF_TURN;
      r.flip = 1'b1;
    end
    r.z = z;
    return r;
  endfunction

  rot_t prot_w [CS+1];
  rot_t arot_w [CS+1];
  rot_t prot_r, arot_r;

  always_ff @(posedge clk) begin
    prot_r <= fold(pol_r);
    arot_r <= fold(az_r);
  end

  assign prot_w[0] = prot_r;
  assign arot_w[0] = arot_r;

  for (genvar k = 0; k < CS; k++) begin : g_cordic
    pptr_cordic_cell #(.STAGE(k)) u_pol (.clk(clk), .rot_i(prot_w[k]), .rot_o(prot_w[k+1]));
    pptr_cordic_cell #(.STAGE(k)) u_az  (.clk(clk), .rot_i(arot_w[k]), .rot_o(arot_w[k+1]));
  end

  // undo fold
  logic signed [XW-1:0] sp_r, cp_r, sa_r, ca_r;
  always_ff @(posedge clk) begin
    sp_r <= prot_w[CS].flip ? -prot_w[CS].y : prot_w[CS].y;
    cp_r <= prot_w[CS].flip ? -prot_w[CS].x : prot_w[CS].x;
    sa_r <= arot_w[CS].flip ? -arot_w[CS].y : arot_w[CS].y;
    ca_r <= arot_w[CS].flip ? -arot_w[CS].x : arot_w[CS].x;
  end

  logic signed [PROD_W-1:0] px_r, py_r, pz_r;
  always_ff @(posedge clk) begin
    px_r <= sp_r * ca_r;
    py_r <= sp_r * sa_r;
    pz_r <= PROD_W'(cp_r);
  end

  // angle delay line
  logic [2*ANG_W-1:0] ang_dly_r [DLY];
  always_ff @(posedge clk) begin
    ang_dly_r[0] <= {az_r, pol_r};
    for (int j = 1; j < DLY; j++) begin
      ang_dly_r[j] <= ang_dly_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    out_azimuth <= ang_dly_r[DLY-1][2*ANG_W-1:ANG_W];
    out_polar   <= ang_dly_r[DLY-1][ANG_W-1:0];
    out_dir_x   <= round_sat16(px_r, 60 - DIR_FRAC_BITS);
    out_dir_y   <= round_sat16(py_r, 60 - DIR_FRAC_BITS);
    out_dir_z   <= round_sat16(pz_r, 30 - DIR_FRAC_BITS);
  end

  assign out_valid = vld_r[LAT-1];
endmodule
